// File: hdl/isq_pkg.sv
// Shared types and constants for the interrupt sequence qualifier.
`default_nettype none
package isq_pkg;

   // Number of tracked interrupt bits (one lane per bit).
   localparam int INT_BITS = 16;
   // Sequence and field width.
   localparam int SEQ_W = 16;
   // Status bits that qualify can report.
   localparam int QUAL_BITS = 15;
   // Qualify lanes actually wired to the result.
   localparam int QUAL_LANES = (INT_BITS < QUAL_BITS) ? INT_BITS : QUAL_BITS;
   // Oldest stamp age kept when a post goes out.
   localparam logic [SEQ_W-1:0] STALE_LIMIT = 16'h3000;

   // Commands carried by an input beat.
   typedef enum logic [1:0] {
      CMD_RESET   = 2'd0,
      CMD_POST    = 2'd1,
      CMD_QUALIFY = 2'd2
   } cmd_type;

   // Control broadcast from the top level to every lane.
   typedef struct packed {
      logic             do_reset;
      logic             do_post;
      logic [SEQ_W-1:0] start_seq;
      logic [SEQ_W-1:0] new_seq;
      logic [SEQ_W-1:0] seen_seq;
   } lane_ctl_type;

   // One result beat.
   typedef struct packed {
      logic                 posted;
      logic [SEQ_W-1:0]     post_seq;
      logic [SEQ_W-1:0]     post_bits;
      logic [SEQ_W-1:0]     post_applied;
      logic [QUAL_BITS-1:0] qualified;
   } rsp_type;

endpackage
`default_nettype wire

// File: hdl/isq_lane.sv
// One interrupt bit lane: holds the bit's post stamp and judges its qualify bit.
`default_nettype none
module isq_lane (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire isq_pkg::lane_ctl_type       ctl,
   input  wire logic                        pending,
   input  wire logic                        data_bit,
   output logic                             qual
);
   import isq_pkg::*;

   logic [SEQ_W-1:0] stamp_ff;
   logic [SEQ_W-1:0] stamp_in;
   logic [SEQ_W-1:0] age;
   logic [SEQ_W-1:0] seen_diff;

   // Age of the stamp against the sequence being posted.
   assign age = ctl.new_seq - stamp_ff;

   // Stamp update: load on reset, restamp pending bits on post, clamp stale ones.
   always_comb begin
      stamp_in = stamp_ff;
      if (ctl.do_reset) begin
         stamp_in = ctl.start_seq;
      end else if (ctl.do_post) begin
         if (pending) begin
            stamp_in = ctl.new_seq;
         end else if ((age > STALE_LIMIT) && !age[SEQ_W-1]) begin
            stamp_in = ctl.new_seq - STALE_LIMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
      end else begin
         stamp_ff <= stamp_in;
      end
   end

   // The bit is trusted when set, not pending, and its last post has been seen.
   assign seen_diff = ctl.seen_seq - stamp_ff;
   assign qual = data_bit && !pending && !seen_diff[SEQ_W-1];

endmodule
`default_nettype wire

// File: hdl/isq_merge.sv
// Merges lane findings into a result beat and buffers it in a two-entry skid.
`default_nettype none
module isq_merge (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_accept,
   output logic                                in_ready,
   input  wire logic                           is_qualify,
   input  wire isq_pkg::rsp_type               post_beat,
   input  wire logic [isq_pkg::INT_BITS-1:0]   lane_qual,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output isq_pkg::rsp_type                    out_beat
);
   import isq_pkg::*;

   rsp_type beat;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;

   // Combine the post fields with the qualify bits gathered from the lanes.
   always_comb begin
      beat = post_beat;
      beat.qualified = '0;
      if (is_qualify) begin
         for (int b = 0; b < QUAL_LANES; b++) begin
            beat.qualified[b] = lane_qual[b];
         end
      end
   end

   // Skid buffer: the main register feeds the port, the skid catches a stalled beat.
   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
         end else begin
            main_in       = beat;
            main_valid_in = in_accept;
         end
         skid_valid_in = 1'b0;
      end else if (in_accept) begin
         skid_in       = beat;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_beat  = main_ff;

endmodule
`default_nettype wire

// File: hdl/interrupt_sequence_qualifier.sv
// Top level of the interrupt sequence qualifier: sequence, pending mask and lanes.
// Usage:
//   Input beats arrive on req_* (valid/ready); each carries a command: reset
//   tracker, try to post, or qualify interrupt data. Every accepted beat
//   produces exactly one result beat on rsp_* (valid/ready).
//   One lane per interrupt bit holds that bit's post stamp; all lanes update
//   in the accept cycle, so a new beat can be taken every clock while
//   req_ready is high. Each result is registered in the output buffer
//   (main register, or skid register when rsp_* stalls) before it is shown.
//   When rsp_ready is held low, a two-entry output skid absorbs one more beat;
//   req_ready then drops until the receiver drains the buffer.
//   Reset (synchronous, active high) clears the sequence, the pending mask,
//   every stamp and the output buffer; req_ready is high the cycle after.
//   A post result shows posted=1 only when bits were pending and the
//   acknowledge matched the current sequence; unused commands return zeros.
`default_nettype none
module interrupt_sequence_qualifier (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [15:0] req_raised,
   input  wire logic [15:0] req_ack_seq,
   input  wire logic [15:0] req_start_seq,
   input  wire logic [15:0] req_applied,
   input  wire logic [15:0] req_int_data,
   input  wire logic [15:0] req_seen_seq,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_posted,
   output logic [15:0]      rsp_post_seq,
   output logic [15:0]      rsp_post_bits,
   output logic [15:0]      rsp_post_applied,
   output logic [14:0]      rsp_qualified
);
   import isq_pkg::*;

   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [INT_BITS-1:0] mask_ff, mask_in;
   logic [INT_BITS-1:0] mask_or;
   logic [INT_BITS-1:0] lane_qual;
   logic                accept;
   logic                is_reset, is_post, is_qualify;
   logic                do_post;
   lane_ctl_type        ctl;
   rsp_type             post_beat;
   rsp_type             out_beat;

   assign accept = req_valid && req_ready;

   // Command decode.
   always_comb begin
      is_reset   = 1'b0;
      is_post    = 1'b0;
      is_qualify = 1'b0;
      unique case (req_cmd)
         CMD_RESET:   is_reset   = 1'b1;
         CMD_POST:    is_post    = 1'b1;
         CMD_QUALIFY: is_qualify = 1'b1;
         default:     ;
      endcase
   end

   // Pending mask with this beat's raised bits folded in.
   assign mask_or = mask_ff | req_raised[INT_BITS-1:0];
   assign do_post = is_post && (mask_or != '0) && (req_ack_seq == seq_ff);

   // Sequence and pending mask updates.
   always_comb begin
      seq_in  = seq_ff;
      mask_in = mask_ff;
      if (accept) begin
         if (is_reset) begin
            seq_in  = req_start_seq;
            mask_in = '0;
         end else if (do_post) begin
            seq_in  = seq_ff + SEQ_W'(1);
            mask_in = '0;
         end else if (is_post || is_qualify) begin
            mask_in = mask_or;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= '0;
         mask_ff <= '0;
      end else begin
         seq_ff  <= seq_in;
         mask_ff <= mask_in;
      end
   end

   // Control broadcast to the lanes.
   always_comb begin
      ctl.do_reset  = accept && is_reset;
      ctl.do_post   = accept && do_post;
      ctl.start_seq = req_start_seq;
      ctl.new_seq   = seq_ff + SEQ_W'(1);
      ctl.seen_seq  = req_seen_seq;
   end

   for (genvar g = 0; g < INT_BITS; g++) begin : g_lane
      isq_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .pending  (mask_or[g]),
         .data_bit (req_int_data[g]),
         .qual     (lane_qual[g])
      );
   end

   // Post fields of the result beat.
   always_comb begin
      post_beat = '0;
      if (do_post) begin
         post_beat.posted                  = 1'b1;
         post_beat.post_seq                = ctl.new_seq;
         post_beat.post_bits[INT_BITS-1:0] = mask_or;
         post_beat.post_applied            = req_applied;
      end
   end

   isq_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (accept),
      .in_ready   (req_ready),
      .is_qualify (is_qualify),
      .post_beat  (post_beat),
      .lane_qual  (lane_qual),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_beat   (out_beat)
   );

   assign rsp_posted       = out_beat.posted;
   assign rsp_post_seq     = out_beat.post_seq;
   assign rsp_post_bits    = out_beat.post_bits;
   assign rsp_post_applied = out_beat.post_applied;
   assign rsp_qualified    = out_beat.qualified;

endmodule
`default_nettype wire

// File: dv/isq_checker.sv
// Result checker for the interrupt sequence qualifier: predicts and compares result beats.
module isq_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [15:0] req_raised,
   input  wire logic [15:0] req_ack_seq,
   input  wire logic [15:0] req_start_seq,
   input  wire logic [15:0] req_applied,
   input  wire logic [15:0] req_int_data,
   input  wire logic [15:0] req_seen_seq,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic        rsp_posted,
   input  wire logic [15:0] rsp_post_seq,
   input  wire logic [15:0] rsp_post_bits,
   input  wire logic [15:0] rsp_post_applied,
   input  wire logic [14:0] rsp_qualified,
   output int               fail_count,
   output int               outstanding,
   output int               beats_checked,
   output int               posts_out,
   output int               clamps
);
   timeunit 1ns;
   timeprecision 1ps;
   import isq_pkg::*;

   // Interrupt bits that exist in this build of the block.
   localparam logic [15:0] LANE_MASK = 16'((32'd1 << INT_BITS) - 1);

   // Local copy of the tracker state.
   logic [15:0] cur_seq;
   logic [15:0] pend_mask;
   logic [15:0] stamp [16];

   // Results still owed by the block, oldest first.
   rsp_type owed_results [$];
   rsp_type want;
   rsp_type got;

   // True when a stamp lags the sequence by more than the stale limit.
   function automatic logic is_stale(input logic [15:0] now, input logic [15:0] stamp_v);
      logic [15:0] age;
      age = now - stamp_v;
      return (age > STALE_LIMIT) && !age[15];
   endfunction

   // True when the reader's sequence is at or past the stamp.
   function automatic logic has_seen(input logic [15:0] seen, input logic [15:0] stamp_v);
      logic [15:0] gap;
      gap = seen - stamp_v;
      return !gap[15];
   endfunction

   // Applies one input beat to the tracker and works out its result.
   task automatic step_tracker(input logic [1:0] cmd, input logic [15:0] raised,
                               input logic [15:0] ack, input logic [15:0] start,
                               input logic [15:0] applied, input logic [15:0] data,
                               input logic [15:0] seen, output rsp_type res);
      logic [15:0] lanes;
      res = '0;
      lanes = raised & LANE_MASK;
      case (cmd)
         CMD_RESET: begin
            cur_seq = start;
            pend_mask = '0;
            for (int b = 0; b < 16; b++) stamp[b] = start;
         end
         CMD_POST: begin
            pend_mask = pend_mask | lanes;
            if (pend_mask != '0 && ack == cur_seq) begin
               cur_seq = cur_seq + 16'd1;
               // Posted bits take the new sequence; idle bits are kept within range.
               for (int b = 0; b < INT_BITS; b++) begin
                  if (pend_mask[b]) begin
                     stamp[b] = cur_seq;
                  end else if (is_stale(cur_seq, stamp[b])) begin
                     stamp[b] = cur_seq - STALE_LIMIT;
                     clamps++;
                  end
               end
               res.posted = 1'b1;
               res.post_seq = cur_seq;
               res.post_bits = pend_mask;
               res.post_applied = applied;
               pend_mask = '0;
               posts_out++;
            end
         end
         CMD_QUALIFY: begin
            pend_mask = pend_mask | lanes;
            for (int b = 0; b < QUAL_LANES; b++) begin
               if (data[b] && !pend_mask[b] && has_seen(seen, stamp[b])) res.qualified[b] = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   // Reports one field that differs from its expected value.
   task automatic check_field(input string fname, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         fail_count++;
         $display("%0t ns: %s expected %h, actual %h", $time, fname, exp_v, act_v);
      end
   endtask

   // Both channels are sampled at the rising edge; the result beat is checked
   // before the new input beat is queued, since the block registers each result.
   always @(posedge clock) begin
      if (reset) begin
         cur_seq = '0;
         pend_mask = '0;
         for (int b = 0; b < 16; b++) stamp[b] = '0;
         owed_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.posted = rsp_posted;
            got.post_seq = rsp_post_seq;
            got.post_bits = rsp_post_bits;
            got.post_applied = rsp_post_applied;
            got.qualified = rsp_qualified;
            if (owed_results.size() == 0) begin
               fail_count++;
               $display("%0t ns: result beat with nothing expected, actual %h", $time, got);
            end else begin
               want = owed_results.pop_front();
               check_field("posted", 16'(want.posted), 16'(got.posted));
               check_field("post_seq", want.post_seq, got.post_seq);
               check_field("post_bits", want.post_bits, got.post_bits);
               check_field("post_applied", want.post_applied, got.post_applied);
               check_field("qualified", 16'(want.qualified), 16'(got.qualified));
               beats_checked++;
            end
         end
         if (req_valid && req_ready) begin
            step_tracker(req_cmd, req_raised, req_ack_seq, req_start_seq, req_applied,
                         req_int_data, req_seen_seq, want);
            owed_results.push_back(want);
         end
      end
      outstanding = owed_results.size();
   end

endmodule

// File: dv/testbench.sv
// Top of the interrupt sequence qualifier testbench: clock, reset, stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import isq_pkg::*;

   // Command code the block does not define.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // Cycles without any beat before the run is declared hung.
   localparam int QUIET_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = '0;
   logic [15:0] req_raised = '0;
   logic [15:0] req_ack_seq = '0;
   logic [15:0] req_start_seq = '0;
   logic [15:0] req_applied = '0;
   logic [15:0] req_int_data = '0;
   logic [15:0] req_seen_seq = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_posted;
   logic [15:0] rsp_post_seq;
   logic [15:0] rsp_post_bits;
   logic [15:0] rsp_post_applied;
   logic [14:0] rsp_qualified;

   int fail_count;
   int outstanding;
   int beats_checked;
   int posts_out;
   int clamps;
   int send_idle_pct = 35;
   int recv_idle_pct = 88;
   int quiet_cycles = 0;

   // Stimulus-side view of the sequence, so most posts carry a matching acknowledge.
   logic [15:0] shadow_seq = '0;
   bit          shadow_pend = 1'b0;

   interrupt_sequence_qualifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_raised       (req_raised),
      .req_ack_seq      (req_ack_seq),
      .req_start_seq    (req_start_seq),
      .req_applied      (req_applied),
      .req_int_data     (req_int_data),
      .req_seen_seq     (req_seen_seq),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_posted       (rsp_posted),
      .rsp_post_seq     (rsp_post_seq),
      .rsp_post_bits    (rsp_post_bits),
      .rsp_post_applied (rsp_post_applied),
      .rsp_qualified    (rsp_qualified)
   );

   isq_checker seq_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_raised       (req_raised),
      .req_ack_seq      (req_ack_seq),
      .req_start_seq    (req_start_seq),
      .req_applied      (req_applied),
      .req_int_data     (req_int_data),
      .req_seen_seq     (req_seen_seq),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_posted       (rsp_posted),
      .rsp_post_seq     (rsp_post_seq),
      .rsp_post_bits    (rsp_post_bits),
      .rsp_post_applied (rsp_post_applied),
      .rsp_qualified    (rsp_qualified),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .beats_checked    (beats_checked),
      .posts_out        (posts_out),
      .clamps           (clamps)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The receiver stalls at random, changing its ready on the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: ends the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Presents one input beat after a random gap and holds it until accepted.
   task automatic send_beat(input logic [1:0] cmd, input logic [15:0] raised,
                            input logic [15:0] ack, input logic [15:0] start,
                            input logic [15:0] applied, input logic [15:0] data,
                            input logic [15:0] seen);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_raised <= raised;
      req_ack_seq <= ack;
      req_start_seq <= start;
      req_applied <= applied;
      req_int_data <= data;
      req_seen_seq <= seen;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      // Keep the stimulus view of the sequence in step.
      case (cmd)
         CMD_RESET: begin
            shadow_seq = start;
            shadow_pend = 1'b0;
         end
         CMD_POST: begin
            shadow_pend = shadow_pend || (raised != '0);
            if (shadow_pend && ack == shadow_seq) begin
               shadow_seq = shadow_seq + 16'd1;
               shadow_pend = 1'b0;
            end
         end
         CMD_QUALIFY: shadow_pend = shadow_pend || (raised != '0);
         default: ;
      endcase
   endtask

   // One random beat, mostly well-formed posts and qualifies near the live sequence.
   task automatic random_beat();
      int          pick;
      logic [15:0] raised;
      logic [15:0] ack;
      logic [15:0] seen;
      pick = $urandom_range(99);
      if ($urandom_range(3) == 0) begin
         raised = '0;
      end else if ($urandom_range(1) == 1) begin
         raised = 16'($urandom);
      end else begin
         raised = 16'($urandom & $urandom & $urandom);
      end
      ack = ($urandom_range(9) < 8) ? shadow_seq : 16'($urandom);
      if ($urandom_range(3) != 0) begin
         seen = shadow_seq + 16'($urandom_range(8)) - 16'd4;
      end else begin
         seen = 16'($urandom);
      end
      if (pick < 4) begin
         send_beat(CMD_RESET, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
      end else if (pick < 6) begin
         send_beat(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
      end else if (pick < 52) begin
         send_beat(CMD_POST, raised, ack, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
      end else begin
         send_beat(CMD_QUALIFY, raised, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), seen);
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed beats: empty state, empty and refused posts, signed-age edges,
      // sequence wrap and the undefined command.
      send_beat(CMD_QUALIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0000);
      send_beat(CMD_POST, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0000);
      send_beat(CMD_POST, 16'hffff, 16'h0001, 16'h0000, 16'hffff, 16'h0000, 16'h0000);
      send_beat(CMD_QUALIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff);
      send_beat(CMD_POST, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_beat(CMD_QUALIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0000);
      send_beat(CMD_QUALIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0001);
      send_beat(CMD_QUALIFY, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h8000);
      send_beat(CMD_QUALIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h8001);
      send_beat(CMD_POST, 16'h0000, 16'h0001, 16'h0000, 16'h5a5a, 16'h0000, 16'h0000);
      send_beat(CMD_RESET, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_beat(CMD_QUALIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hfffe);
      send_beat(CMD_POST, 16'h8000, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_beat(CMD_QUALIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000);
      send_beat(CMD_QUALIFY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff);
      send_beat(CMD_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_beat(CMD_POST, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_beat(CMD_RESET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_beat(CMD_POST, 16'h4000, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000);

      // Random beats with the sender idling lightly and the receiver heavily.
      repeat (280) random_beat();

      // Swap the idle pattern.
      send_idle_pct = 88;
      recv_idle_pct = 35;
      repeat (285) random_beat();

      // Neither side idles from here on.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (285) random_beat();
      req_valid <= 1'b0;

      // Drain: wait until every result has arrived, then give the verdict.
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(negedge clock);

      $display("Checked %0d result beats across three idle patterns; %0d posts went out.",
               beats_checked, posts_out);
      $display("Stale stamps were clamped %0d times.", clamps);
      if (fail_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
